@@ sv/imucf_pkg.sv @@
// Shared types, constants and helper functions of the IMU complementary filter.
package imucf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_FRAC_DEF   = 16;
   localparam int TAB_FRAC         = 24;

   localparam int CORDIC_W   = 36;
   localparam int SQ_W       = 64;
   localparam int ANGLE_W    = 32;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_AXIS_GAIN  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_SCALE   = 4'd2;

   localparam logic [16:0] BLEND_WEIGHT_RST = 17'd62915;
   localparam logic [15:0] Z_AXIS_GAIN_RST  = 16'd18618;
   localparam logic [15:0] GYRO_SCALE_RST   = 16'd32786;
   localparam logic [16:0] ONE_Q16          = 17'd65536;

   // atan(2^-i) in Q24 degrees
   localparam logic [29:0] ATAN_Q24 [32] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
      30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
      30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
      30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
      30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
   };

   typedef enum logic [4:0] {
      S_IDLE, S_MZ, S_SQX, S_SQY, S_SQZ, S_GX, S_GY, S_GZ, S_SX, S_SY, S_SZ,
      S_YAW, S_VROLL, S_VPITCH, S_BR1, S_BR2, S_BP1, S_BP2, S_BP3, S_OUT
   } cf_state_type;

   typedef enum logic [1:0] {
      V_IDLE, V_ROOT, V_ROT, V_DONE
   } vec_state_type;

   typedef struct packed {
      logic                       start;
      logic [SQ_W-1:0]            sum_sq;
      logic signed [ANGLE_W-1:0]  num;
   } vec_cmd_type;

   typedef struct packed {
      logic                       idle;
      logic                       done;
      logic signed [ANGLE_W-1:0]  angle;
   } vec_rsp_type;

   // Step angle rounded half up from Q24 to the working angle format
   function automatic logic signed [ANGLE_W-1:0] step_angle(input logic [4:0] idx,
                                                           input int unsigned frac);
      logic [ANGLE_W-1:0] t;
      int unsigned        sh;
      t  = {2'b00, ATAN_Q24[idx]};
      sh = TAB_FRAC - frac;
      if (sh == 0) begin
         return t;
      end
      return (t + (32'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

@@ sv/imucf_ifs.sv @@
// Channel interfaces of the IMU complementary filter: sample, result and register write.
interface imucf_req_if import imucf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] accel_x;
   logic signed [SAMPLE_W-1:0] accel_y;
   logic signed [SAMPLE_W-1:0] accel_z;
   logic signed [SAMPLE_W-1:0] gyro_x;
   logic signed [SAMPLE_W-1:0] gyro_y;
   logic signed [SAMPLE_W-1:0] gyro_z;
   logic [SAMPLE_W-1:0]        elapsed_ms;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   elapsed_ms, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   elapsed_ms, output ready);
endinterface

interface imucf_rsp_if import imucf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] roll_deg;
   logic signed [ANGLE_W-1:0] pitch_deg;
   logic signed [ANGLE_W-1:0] yaw_deg;

   modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
   modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface imucf_csr_if import imucf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/imucf_vec.sv @@
// Iterative vector-angle unit: integer square root, then CORDIC vectoring.
module imucf_vec import imucf_pkg::*; #(
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  vec_cmd_type cmd,
   output vec_rsp_type rsp
);

   localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
   localparam logic signed [ANGLE_W-1:0] Z_LIMIT = 32'(100 << ANGLE_FRAC_BITS);

   vec_state_type state_ff, state_in;

   logic [SQ_W-1:0]              rem_ff, rem_in;
   logic [SQ_W-1:0]              root_ff, root_in;
   logic [SQ_W-1:0]              place_ff, place_in;
   logic signed [ANGLE_W-1:0]    num_ff, num_in;
   logic signed [CORDIC_W-1:0]   x_ff, x_in;
   logic signed [CORDIC_W-1:0]   y_ff, y_in;
   logic signed [ANGLE_W-1:0]    z_ff, z_in;
   logic [4:0]                   step_ff, step_in;

   logic [SQ_W-1:0]              trial;
   logic signed [CORDIC_W-1:0]   dx;
   logic signed [CORDIC_W-1:0]   dy;
   logic signed [ANGLE_W-1:0]    ang;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= V_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      place_ff <= place_in;
      num_ff   <= num_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      step_ff  <= step_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      place_in = place_ff;
      num_in   = num_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      trial    = root_ff + place_ff;
      dx       = y_ff >>> step_ff;
      dy       = x_ff >>> step_ff;
      ang      = step_angle(step_ff, ANGLE_FRAC_BITS);

      rsp.idle  = (state_ff == V_IDLE) || (state_ff == V_DONE);
      rsp.done  = (state_ff == V_DONE);
      rsp.angle = z_ff;

      unique case (state_ff)
         V_IDLE, V_DONE: begin
            state_in = V_IDLE;
            if (cmd.start) begin
               rem_in   = cmd.sum_sq;
               root_in  = '0;
               place_in = 64'h4000_0000_0000_0000;
               num_in   = cmd.num;
               state_in = V_ROOT;
            end
         end
         V_ROOT: begin
            // one root bit per cycle
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + place_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            place_in = place_ff >> 2;
            if (place_ff[0]) begin
               x_in    = CORDIC_W'(root_in[31:0]);
               y_in    = CORDIC_W'(num_ff);
               z_in    = '0;
               step_in = '0;
               // both vector components zero: angle stays zero
               if (root_in == '0 && num_ff == '0) begin
                  state_in = V_DONE;
               end else begin
                  state_in = V_ROT;
               end
            end
         end
         V_ROT: begin
            if (!y_ff[CORDIC_W-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + ang;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - ang;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = V_DONE;
            end
         end
         default: begin
            state_in = V_IDLE;
         end
      endcase
   end

   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      state_ff == V_ROT |-> !x_ff[CORDIC_W-1])
      else $error("vectoring x went negative");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == V_DONE |-> (z_ff <= Z_LIMIT && z_ff >= -Z_LIMIT))
      else $error("vector angle beyond 100 degrees");

   a_root_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == V_ROOT && place_ff[0]) |=> (state_ff == V_ROT || state_ff == V_DONE))
      else $error("square root did not finish on the last place");

endmodule

@@ sv/imu_complementary_filter.sv @@
// Top level of the IMU complementary attitude filter.
//
//   channel  modport  carries                                         handshake
//   req_ch   sink     accel_x/y/z, gyro_x/y/z, elapsed_ms              valid/ready
//   rsp_ch   source   roll_deg, pitch_deg, yaw_deg (Q.ANGLE_FRAC_BITS) valid/ready
//   csr_ch   sink     index, data (blend_weight, z_axis_gain, gyro_scale) valid/ready
//
// A request holds the block until its result is registered: the accept step, the vector
// passes (square root, a hand-off step, CORDIC rotations), the steps on the one shared
// 33x33 multiplier and the output step.
// An all-zero vector skips its rotations. Reset is synchronous: estimates go to zero,
// registers to their defaults. The result has its own register, so the next request is
// taken while it waits; the block then holds in S_OUT until rsp_ch frees. csr_ch: always ready.
module imu_complementary_filter import imucf_pkg::*; #(
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic        clock,
   input  logic        reset,
   imucf_req_if.sink   req_ch,
   imucf_rsp_if.source rsp_ch,
   imucf_csr_if.sink   csr_ch
);

   // gyro delta: product shifted down to the angle format
   localparam int SH      = 32 - ANGLE_FRAC_BITS;
   localparam int DELTA_W = 50 - SH;

   cf_state_type state_ff, state_in;

   // configuration
   logic [16:0] blend_w_ff, blend_w_in;
   logic [15:0] z_gain_ff, z_gain_in;
   logic [15:0] g_scale_ff, g_scale_in;

   // filter state
   logic signed [ANGLE_W-1:0] roll_ff, roll_in;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;
   logic signed [ANGLE_W-1:0] yaw_ff, yaw_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] out_roll_ff, out_roll_in;
   logic signed [ANGLE_W-1:0] out_pitch_ff, out_pitch_in;
   logic signed [ANGLE_W-1:0] out_yaw_ff, out_yaw_in;

   // captured sample
   logic signed [SAMPLE_W-1:0] ax_ff, ax_in;
   logic signed [SAMPLE_W-1:0] ay_ff, ay_in;
   logic signed [SAMPLE_W-1:0] az_ff, az_in;
   logic signed [SAMPLE_W-1:0] gx_ff, gx_in;
   logic signed [SAMPLE_W-1:0] gy_ff, gy_in;
   logic signed [SAMPLE_W-1:0] gz_ff, gz_in;
   logic [SAMPLE_W-1:0]        ms_ff, ms_in;

   // working registers
   logic signed [65:0]        prod_ff, prod_in;
   logic [30:0]               azm_ff, azm_in;
   logic [SQ_W-1:0]           sqx_ff, sqx_in;
   logic [SQ_W-1:0]           sqy_ff, sqy_in;
   logic [SQ_W-1:0]           sqz_ff, sqz_in;
   logic signed [31:0]        rmx_ff, rmx_in;
   logic signed [31:0]        rmy_ff, rmy_in;
   logic signed [31:0]        rmz_ff, rmz_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic signed [ANGLE_W-1:0] gpr_ff, gpr_in;
   logic signed [ANGLE_W-1:0] gpp_ff, gpp_in;
   logic signed [ANGLE_W-1:0] accr_ff, accr_in;
   logic signed [ANGLE_W-1:0] accp_ff, accp_in;
   logic signed [49:0]        t_ff, t_in;

   // shared multiplier operands
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;

   logic [15:0] axm;
   logic [15:0] aym;
   logic [15:0] azm_raw;
   logic [16:0] w_eff;
   logic [16:0] w_rest;
   logic        rsp_free;

   vec_cmd_type vec_cmd;
   vec_rsp_type vec_rsp;

   imucf_vec #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_vec (
      .clock (clock),
      .reset (reset),
      .cmd   (vec_cmd),
      .rsp   (vec_rsp)
   );

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      return v[15] ? (~v + 16'd1) : v;
   endfunction

   // round half up toward plus infinity, then drop the low bits
   function automatic logic signed [DELTA_W-1:0] rnd_delta(input logic signed [48:0] p);
      logic signed [49:0] s;
      s = 50'(p) + (50'sd1 <<< (SH - 1));
      return DELTA_W'(s >>> SH);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] blend_round(input logic signed [49:0] a,
                                                             input logic signed [49:0] b);
      logic signed [51:0] s;
      s = 52'(a) + 52'(b) + 52'sd32768;
      return sat32(64'(s >>> 16));
   endfunction

   assign axm     = mag16(ax_ff);
   assign aym     = mag16(ay_ff);
   assign azm_raw = mag16(az_ff);
   // weights above one act as one
   assign w_eff   = (blend_w_ff > ONE_Q16) ? ONE_Q16 : blend_w_ff;
   assign w_rest  = ONE_Q16 - w_eff;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.roll_deg  = out_roll_ff;
   assign rsp_ch.pitch_deg = out_pitch_ff;
   assign rsp_ch.yaw_deg   = out_yaw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         blend_w_ff   <= BLEND_WEIGHT_RST;
         z_gain_ff    <= Z_AXIS_GAIN_RST;
         g_scale_ff   <= GYRO_SCALE_RST;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         blend_w_ff   <= blend_w_in;
         z_gain_ff    <= z_gain_in;
         g_scale_ff   <= g_scale_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
      end
   end

   always_ff @(posedge clock) begin
      out_roll_ff  <= out_roll_in;
      out_pitch_ff <= out_pitch_in;
      out_yaw_ff   <= out_yaw_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      gz_ff   <= gz_in;
      ms_ff   <= ms_in;
      prod_ff <= prod_in;
      azm_ff  <= azm_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      sqz_ff  <= sqz_in;
      rmx_ff  <= rmx_in;
      rmy_ff  <= rmy_in;
      rmz_ff  <= rmz_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      gpr_ff  <= gpr_in;
      gpp_ff  <= gpp_in;
      accr_ff <= accr_in;
      accp_ff <= accp_in;
      t_ff    <= t_in;
   end

   // register writes; unknown indexes drop
   always_comb begin
      blend_w_in = blend_w_ff;
      z_gain_in  = z_gain_ff;
      g_scale_in = g_scale_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_BLEND_WEIGHT: blend_w_in = csr_ch.data;
            CSR_Z_AXIS_GAIN:  z_gain_in  = csr_ch.data[15:0];
            CSR_GYRO_SCALE:   g_scale_in = csr_ch.data[15:0];
            default: ;
         endcase
      end
   end

   // the shared multiplier: one product per cycle, registered
   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_roll_in  = out_roll_ff;
      out_pitch_in = out_pitch_ff;
      out_yaw_in   = out_yaw_ff;
      roll_in  = roll_ff;
      pitch_in = pitch_ff;
      yaw_in   = yaw_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      az_in    = az_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      gz_in    = gz_ff;
      ms_in    = ms_ff;
      azm_in   = azm_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      sqz_in   = sqz_ff;
      rmx_in   = rmx_ff;
      rmy_in   = rmy_ff;
      rmz_in   = rmz_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      gpr_in   = gpr_ff;
      gpp_in   = gpp_ff;
      accr_in  = accr_ff;
      accp_in  = accp_ff;
      t_in     = t_ff;
      mul_a    = '0;
      mul_b    = '0;
      vec_cmd  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               ax_in    = req_ch.accel_x;
               ay_in    = req_ch.accel_y;
               az_in    = req_ch.accel_z;
               gx_in    = req_ch.gyro_x;
               gy_in    = req_ch.gyro_y;
               gz_in    = req_ch.gyro_z;
               ms_in    = req_ch.elapsed_ms;
               state_in = S_MZ;
            end
         end
         // rescale Z to the X/Y scale, magnitude only
         S_MZ: begin
            mul_a    = {17'd0, azm_raw};
            mul_b    = {17'd0, z_gain_ff};
            state_in = S_SQX;
         end
         S_SQX: begin
            azm_in   = prod_ff[30:0];
            mul_a    = {17'd0, axm};
            mul_b    = {17'd0, axm};
            state_in = S_SQY;
         end
         // X and Y carry a factor of 2^14, so their squares shift by 28
         S_SQY: begin
            sqx_in   = SQ_W'(prod_ff[31:0]) << 28;
            mul_a    = {17'd0, aym};
            mul_b    = {17'd0, aym};
            state_in = S_SQZ;
         end
         S_SQZ: begin
            sqy_in   = SQ_W'(prod_ff[31:0]) << 28;
            mul_a    = {2'b00, azm_ff};
            mul_b    = {2'b00, azm_ff};
            state_in = S_GX;
         end
         // gyro rate times elapsed time
         S_GX: begin
            sqz_in   = prod_ff[63:0];
            mul_a    = {{17{gx_ff[15]}}, gx_ff};
            mul_b    = {17'd0, ms_ff};
            state_in = S_GY;
         end
         S_GY: begin
            rmx_in   = prod_ff[31:0];
            mul_a    = {{17{gy_ff[15]}}, gy_ff};
            mul_b    = {17'd0, ms_ff};
            state_in = S_GZ;
         end
         S_GZ: begin
            rmy_in   = prod_ff[31:0];
            mul_a    = {{17{gz_ff[15]}}, gz_ff};
            mul_b    = {17'd0, ms_ff};
            state_in = S_SX;
         end
         // then times the gyro scale
         S_SX: begin
            rmz_in   = prod_ff[31:0];
            mul_a    = {rmx_ff[31], rmx_ff};
            mul_b    = {17'd0, g_scale_ff};
            state_in = S_SY;
         end
         S_SY: begin
            dx_in    = rnd_delta(prod_ff[48:0]);
            mul_a    = {rmy_ff[31], rmy_ff};
            mul_b    = {17'd0, g_scale_ff};
            state_in = S_SZ;
         end
         S_SZ: begin
            dy_in    = rnd_delta(prod_ff[48:0]);
            mul_a    = {rmz_ff[31], rmz_ff};
            mul_b    = {17'd0, g_scale_ff};
            state_in = S_YAW;
         end
         // yaw integrates gyro Z; propagate roll and pitch; start roll vector
         S_YAW: begin
            yaw_in         = sat32(64'(yaw_ff) + 64'(rnd_delta(prod_ff[48:0])));
            gpr_in         = sat32(64'(roll_ff) + 64'(dy_ff));
            gpp_in         = sat32(64'(pitch_ff) + 64'(dx_ff));
            vec_cmd.start  = 1'b1;
            vec_cmd.sum_sq = sqy_ff + sqz_ff;
            vec_cmd.num    = -(32'(ax_ff) <<< 14);
            state_in       = S_VROLL;
         end
         S_VROLL: begin
            if (vec_rsp.done) begin
               accr_in        = vec_rsp.angle;
               vec_cmd.start  = 1'b1;
               vec_cmd.sum_sq = sqx_ff + sqz_ff;
               vec_cmd.num    = 32'(ay_ff) <<< 14;
               state_in       = S_VPITCH;
            end
         end
         S_VPITCH: begin
            if (vec_rsp.done) begin
               accp_in  = vec_rsp.angle;
               state_in = S_BR1;
            end
         end
         // blend: alpha on the gyro path, one minus alpha on the accel angle
         S_BR1: begin
            mul_a    = {16'd0, w_eff};
            mul_b    = {gpr_ff[31], gpr_ff};
            state_in = S_BR2;
         end
         S_BR2: begin
            t_in     = prod_ff[49:0];
            mul_a    = {16'd0, w_rest};
            mul_b    = {accr_ff[31], accr_ff};
            state_in = S_BP1;
         end
         S_BP1: begin
            roll_in  = blend_round(t_ff, prod_ff[49:0]);
            mul_a    = {16'd0, w_eff};
            mul_b    = {gpp_ff[31], gpp_ff};
            state_in = S_BP2;
         end
         S_BP2: begin
            t_in     = prod_ff[49:0];
            mul_a    = {16'd0, w_rest};
            mul_b    = {accp_ff[31], accp_ff};
            state_in = S_BP3;
         end
         S_BP3: begin
            pitch_in = blend_round(t_ff, prod_ff[49:0]);
            state_in = S_OUT;
         end
         // hold until the result register frees
         S_OUT: begin
            if (rsp_free) begin
               out_roll_in  = roll_ff;
               out_pitch_in = pitch_ff;
               out_yaw_in   = yaw_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_vec_start_idle: assert property (@(posedge clock) disable iff (reset)
      vec_cmd.start |-> vec_rsp.idle)
      else $error("vector unit started while busy");

   a_roll_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_BP1 |=> $stable(roll_ff))
      else $error("roll estimate changed outside its commit step");

   a_pitch_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_BP3 |=> $stable(pitch_ff))
      else $error("pitch estimate changed outside its commit step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output step");

endmodule
